/* hdl/brb_pkg.sv */
// bip buffer manager package: operation codes, request, result and state types
// no dependencies; used by every module of the block
package brb_pkg;

  localparam int unsigned PosW = 13;
  localparam int unsigned OffW = 12;
  localparam int unsigned SumW = PosW + 1;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_READ    = 2'd2,
    OP_CONSUME = 2'd3
  } brb_op_e;

  typedef struct packed {
    brb_op_e           op;
    logic [PosW-1:0]   len;
    logic [OffW-1:0]   start;
  } brb_req_t;

  typedef struct packed {
    logic              ok;
    logic [OffW-1:0]   offset;
    logic [PosW-1:0]   avail;
  } brb_rsp_t;

  typedef struct packed {
    logic [PosW-1:0]   read_pos;
    logic [PosW-1:0]   write_pos;
    logic [PosW-1:0]   high_mark;
    logic [PosW-1:0]   pend_start;
    logic              pend_wrapped;
    logic [PosW-1:0]   pend_prior;
  } brb_state_t;

endpackage

/* hdl/brb_req_stage.sv */
// request input register of the bip buffer manager
// depends on brb_pkg for the request type
module brb_req_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  brb_pkg::brb_req_t req_i,
  output logic              valid_o,
  output brb_pkg::brb_req_t req_o
);

  logic              valid_q;
  brb_pkg::brb_req_t req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

/* hdl/brb_engine.sv */
// next-state and result logic of the bip buffer manager for one transaction
// depends on brb_pkg for the request, result and state types
module brb_engine (
  input  logic [brb_pkg::PosW-1:0] cap_i,
  input  brb_pkg::brb_req_t        req_i,
  input  brb_pkg::brb_state_t      st_i,
  output brb_pkg::brb_state_t      st_o,
  output brb_pkg::brb_rsp_t        rsp_o
);

  logic [brb_pkg::PosW-1:0] w;
  logic [brb_pkg::PosW-1:0] r;
  logic [brb_pkg::PosW-1:0] room;
  logic [brb_pkg::PosW-1:0] at;
  logic [brb_pkg::PosW-1:0] sz;
  logic [brb_pkg::PosW-1:0] rd_at;
  logic [brb_pkg::SumW-1:0] commit_sum;
  logic [brb_pkg::SumW-1:0] consume_sum;
  logic [brb_pkg::PosW-1:0] commit_pos;
  logic [brb_pkg::PosW-1:0] consume_pos;
  logic                     grant;
  logic                     wrapped;

  assign commit_sum  = {1'b0, st_i.pend_start} + {1'b0, req_i.len};
  assign consume_sum = {2'b00, req_i.start} + {1'b0, req_i.len};
  assign commit_pos  = (commit_sum > {1'b0, cap_i}) ? cap_i
                                                    : commit_sum[brb_pkg::PosW-1:0];
  assign consume_pos = (consume_sum > {1'b0, cap_i}) ? cap_i
                                                     : consume_sum[brb_pkg::PosW-1:0];

  // reserve placement
  always_comb begin
    w       = st_i.write_pos;
    r       = st_i.read_pos;
    grant   = 1'b0;
    wrapped = 1'b0;
    at      = '0;
    room    = '0;
    if (w >= r) begin
      if (w == r) begin
        w = '0;
        r = '0;
      end
      room = (w > cap_i) ? '0 : cap_i - w;
      if (room >= req_i.len) begin
        grant = 1'b1;
        at    = w;
      end else if (r > req_i.len) begin
        grant   = 1'b1;
        wrapped = 1'b1;
      end
    end else if ((r - w) > req_i.len) begin
      grant = 1'b1;
      at    = w;
    end
  end

  // readable region
  always_comb begin
    rd_at = st_i.read_pos;
    if (st_i.write_pos >= st_i.read_pos) begin
      sz = st_i.write_pos - st_i.read_pos;
    end else if (st_i.read_pos == st_i.high_mark) begin
      rd_at = '0;
      sz    = st_i.write_pos;
    end else if (st_i.high_mark >= st_i.read_pos) begin
      sz = st_i.high_mark - st_i.read_pos;
    end else begin
      sz = '0;
    end
  end

  always_comb begin
    st_o  = st_i;
    rsp_o = '0;
    unique case (req_i.op)
      brb_pkg::OP_RESERVE: begin
        st_o.read_pos  = r;
        st_o.write_pos = w;
        if (grant) begin
          st_o.pend_start   = at;
          st_o.pend_wrapped = wrapped;
          st_o.pend_prior   = w;
          rsp_o.ok          = 1'b1;
          rsp_o.offset      = at[brb_pkg::OffW-1:0];
        end
      end
      brb_pkg::OP_COMMIT: begin
        if (req_i.len != '0) begin
          if (st_i.pend_wrapped) begin
            st_o.high_mark = st_i.pend_prior;
          end
          st_o.write_pos = commit_pos;
        end
        rsp_o.ok = 1'b1;
      end
      brb_pkg::OP_READ: begin
        if (sz != '0) begin
          rsp_o.ok     = 1'b1;
          rsp_o.offset = rd_at[brb_pkg::OffW-1:0];
          rsp_o.avail  = sz;
        end
      end
      brb_pkg::OP_CONSUME: begin
        st_o.read_pos = consume_pos;
        rsp_o.ok      = 1'b1;
      end
      default: begin
        st_o  = st_i;
        rsp_o = '0;
      end
    endcase
  end

endmodule

/* hdl/bipartite_ring_buffer_manager.sv */
// top level of the bip buffer manager: capacity register, offset state, result register
// depends on brb_pkg, brb_req_stage and brb_engine
//
// usage
//   request channel: operation_i, length_i and region_start_i are taken at a
//   rising edge with start high and busy low; busy stays low, so a new
//   transaction can be started in every cycle
//   result channel: result_valid_o is high for exactly one cycle per request,
//   with ok_o, offset_o and avail_o valid in that cycle; the receiver has no
//   way to stall it and must take each result when it appears
//   capacity: cfg_we_i writes cfg_wdata_i, clamped into 1..MAX_BYTES, while idle
//   latency: 2 cycles from request to result (input register, then the
//   offset update and result register); throughput is one request per cycle,
//   set by the single-cycle update of the offset registers
//   reset: rst_ni low clears the offsets and the pending reservation, sets the
//   capacity to 4096 (or MAX_BYTES if smaller) and the high mark to match,
//   and drops any transaction in flight
module bipartite_ring_buffer_manager #(
  parameter int unsigned MAX_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [brb_pkg::PosW-1:0] length_i,
  input  logic [brb_pkg::OffW-1:0] region_start_i,
  input  logic                     cfg_we_i,
  input  logic [brb_pkg::PosW-1:0] cfg_wdata_i,
  output logic                     result_valid_o,
  output logic                     ok_o,
  output logic [brb_pkg::OffW-1:0] offset_o,
  output logic [brb_pkg::PosW-1:0] avail_o
);

  localparam int unsigned PosMax   = (1 << brb_pkg::PosW) - 1;
  localparam int unsigned CapLimit = (MAX_BYTES > PosMax) ? PosMax : MAX_BYTES;
  localparam int unsigned CapInit  = (MAX_BYTES > 4096) ? 4096 : MAX_BYTES;
  localparam logic [brb_pkg::PosW-1:0] CapLimitW = CapLimit[brb_pkg::PosW-1:0];
  localparam logic [brb_pkg::PosW-1:0] CapInitW  = CapInit[brb_pkg::PosW-1:0];

  logic                     accept;
  brb_pkg::brb_req_t        req_in;
  brb_pkg::brb_req_t        req;
  logic                     req_valid;
  logic [brb_pkg::PosW-1:0] cap_q;
  logic [brb_pkg::PosW-1:0] cap_d;
  brb_pkg::brb_state_t      st_q;
  brb_pkg::brb_state_t      st_d;
  brb_pkg::brb_rsp_t        rsp_d;
  brb_pkg::brb_rsp_t        rsp_q;
  logic                     rvalid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign req_in.op    = brb_pkg::brb_op_e'(operation_i);
  assign req_in.len   = length_i;
  assign req_in.start = region_start_i;

  assign cap_d = (cfg_wdata_i == '0)       ? {{(brb_pkg::PosW-1){1'b0}}, 1'b1} :
                 (cfg_wdata_i > CapLimitW) ? CapLimitW : cfg_wdata_i;

  brb_req_stage u_req (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_in),
    .valid_o  (req_valid),
    .req_o    (req)
  );

  brb_engine u_eng (
    .cap_i (cap_q),
    .req_i (req),
    .st_i  (st_q),
    .st_o  (st_d),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapInitW;
      st_q     <= '{read_pos: '0, write_pos: '0, high_mark: CapInitW,
                    pend_start: '0, pend_wrapped: 1'b0, pend_prior: '0};
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cap_d;
      end
      if (req_valid) begin
        st_q <= st_d;
      end
      rvalid_q <= req_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = rvalid_q;
  assign ok_o           = rsp_q.ok;
  assign offset_o       = rsp_q.offset;
  assign avail_o        = rsp_q.avail;

endmodule

/* hdl/brb_checker.sv */
// port-level checks of the bip buffer manager, bound to the top level
// depends on brb_pkg for the operation codes
module brb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               operation_i,
  input logic                     result_valid_o,
  input logic                     ok_o,
  input logic [brb_pkg::OffW-1:0] offset_o,
  input logic [brb_pkg::PosW-1:0] avail_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without request");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !ok_o |-> offset_o == '0 && avail_o == '0)
    else $error("refused result carries data");

  a_update_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == brb_pkg::OP_COMMIT ||
                       operation_i == brb_pkg::OP_CONSUME)
    |-> ##2 ok_o && offset_o == '0 && avail_o == '0)
    else $error("commit or consume result wrong");

endmodule

bind bipartite_ring_buffer_manager brb_checker u_brb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .ok_o           (ok_o),
  .offset_o       (offset_o),
  .avail_o        (avail_o)
);
